@@ design/rsa_modular_exponentiation_core_assert.svh @@
// ----------------------------------------------------------------------------
// RSA modular exponentiation core: assertion macros
// Shared property shorthands that expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef RSA_MODULAR_EXPONENTIATION_CORE_ASSERT_SVH
`define RSA_MODULAR_EXPONENTIATION_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define RSA_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define RSA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/rsa_mexp_pkg.sv @@
// ----------------------------------------------------------------------------
// RSA modular exponentiation package
// Shared constants, register indexes, sequencer states and unit status type.
// ----------------------------------------------------------------------------
package rsa_mexp_pkg;

    // Default word width of message, modulus, exponents and result.
    localparam int WORD_WIDTH_DEF = 32;

    // Configuration register indexes.
    localparam int CFG_INDEX_WIDTH = 2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MODULUS          = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PUBLIC_EXPONENT  = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PRIVATE_EXPONENT = 2'd2;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_STEP,
        ST_MULT,
        ST_SQUARE,
        ST_FINISH
    } state_t;

    // Status of the shared modular multiplier.
    typedef struct packed {
        logic busy;
        logic done;
    } mm_status_t;

endpackage

@@ design/rsa_mexp_mulmod.sv @@
// ----------------------------------------------------------------------------
// RSA modular exponentiation: shared modular multiplier
// Bit-serial double-and-add multiply, one multiplier bit per cycle, with the
// running sum kept below the modulus. A modulus of zero means 2^WORD_WIDTH.
// ----------------------------------------------------------------------------
module rsa_mexp_mulmod
    import rsa_mexp_pkg::*;
#(
    parameter int WORD_WIDTH = WORD_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [WORD_WIDTH-1:0] x,
    input  logic [WORD_WIDTH-1:0] y,
    input  logic [WORD_WIDTH-1:0] modulus,
    output mm_status_t            status,
    output logic [WORD_WIDTH-1:0] product
);

    localparam int CNT_WIDTH = $clog2(WORD_WIDTH);
    localparam int SUM_WIDTH = WORD_WIDTH + 2;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_WIDTH-1:0]  cnt_reg, cnt_next;
    logic [WORD_WIDTH-1:0] x_reg, x_next;
    logic [WORD_WIDTH-1:0] y_reg, y_next;
    logic [WORD_WIDTH-1:0] r_reg, r_next;

    logic [SUM_WIDTH-1:0]  sum;
    logic [SUM_WIDTH-1:0]  mod_once;
    logic [SUM_WIDTH-1:0]  mod_twice;
    logic [SUM_WIDTH-1:0]  sum_red;
    logic [WORD_WIDTH-1:0] r_step;

    // One step: r = 2r + bit * x, then bring it below the modulus.
    // With r and x below the modulus the sum stays below three times it.
    always_comb
    begin
        sum       = {1'b0, r_reg, 1'b0}
                  + (y_reg[WORD_WIDTH-1] ? {2'b00, x_reg} : '0);
        mod_once  = {2'b00, modulus};
        mod_twice = {1'b0, modulus, 1'b0};
        if (sum >= mod_twice)
        begin
            sum_red = sum - mod_twice;
        end
        else if (sum >= mod_once)
        begin
            sum_red = sum - mod_once;
        end
        else
        begin
            sum_red = sum;
        end
        // A zero modulus stands for 2^WORD_WIDTH: the sum simply wraps.
        if (modulus == '0)
        begin
            r_step = sum[WORD_WIDTH-1:0];
        end
        else
        begin
            r_step = sum_red[WORD_WIDTH-1:0];
        end
    end

    // Operand load on start, then one multiplier bit per cycle, MSB first.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        r_next    = r_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_WIDTH'(WORD_WIDTH - 1);
            x_next    = x;
            y_next    = y;
            r_next    = '0;
        end
        else if (busy_reg)
        begin
            r_next = r_step;
            y_next = {y_reg[WORD_WIDTH-2:0], 1'b0};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        r_reg <= r_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign product     = r_reg;

endmodule

@@ design/rsa_modular_exponentiation_core.sv @@
// ----------------------------------------------------------------------------
// RSA modular exponentiation core
// Right-to-left square-and-multiply over one shared modular multiplier.
// ----------------------------------------------------------------------------
// Each input beat carries a message and an operation (0 encrypt with the public
// exponent, 1 decrypt with the private exponent); one output beat returns the
// message raised to that exponent modulo the configured modulus, or 1 for a
// zero exponent. A modulus of zero acts as 2^WORD_WIDTH. One item at a time is
// processed and in_ready stays low meanwhile. All arithmetic runs through a
// single bit-serial modular multiplier, one product at a time: first it
// reduces the message, then for each significant exponent bit the sequencer
// decides in ST_STEP and starts up to two products, a multiply and a square.
// The result sits in an output register, so a new item may be accepted
// before it is taken.
// Configuration writes take effect at once, so they must only be made while
// the core is idle and no item is in flight.
// ----------------------------------------------------------------------------
module rsa_modular_exponentiation_core
    import rsa_mexp_pkg::*;
#(
    parameter int WORD_WIDTH = WORD_WIDTH_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    // Configuration write port
    input  logic                       cfg_write,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [WORD_WIDTH-1:0]      cfg_data,
    // Input channel
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       operation,
    input  logic [WORD_WIDTH-1:0]      message,
    // Output channel
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [WORD_WIDTH-1:0]      result
);

    logic [WORD_WIDTH-1:0] modulus_reg;
    logic [WORD_WIDTH-1:0] pub_exp_reg;
    logic [WORD_WIDTH-1:0] priv_exp_reg;

    state_t                state_reg, state_next;
    logic [WORD_WIDTH-1:0] exp_reg, exp_next;
    logic [WORD_WIDTH-1:0] acc_reg, acc_next;
    logic [WORD_WIDTH-1:0] base_reg, base_next;
    logic                  out_valid_reg, out_valid_next;
    logic [WORD_WIDTH-1:0] result_reg, result_next;

    logic                  mm_start;
    logic [WORD_WIDTH-1:0] mm_x;
    logic [WORD_WIDTH-1:0] mm_y;
    mm_status_t            mm_status;
    logic [WORD_WIDTH-1:0] mm_product;

    // Configuration registers; an index beyond the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg  <= WORD_WIDTH'(2);
            pub_exp_reg  <= '0;
            priv_exp_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_MODULUS:          modulus_reg  <= cfg_data;
                CFG_PUBLIC_EXPONENT:  pub_exp_reg  <= cfg_data;
                CFG_PRIVATE_EXPONENT: priv_exp_reg <= cfg_data;
                default:              ;
            endcase
        end
    end

    // Shared modular multiplier.
    rsa_mexp_mulmod #(
        .WORD_WIDTH (WORD_WIDTH)
    ) u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mm_start),
        .x       (mm_x),
        .y       (mm_y),
        .modulus (modulus_reg),
        .status  (mm_status),
        .product (mm_product)
    );

    assign in_ready = (state_reg == ST_IDLE) && !mm_status.busy;

    // Sequencer: reduce the message, then walk the exponent from its LSB.
    always_comb
    begin
        state_next     = state_reg;
        exp_next       = exp_reg;
        acc_next       = acc_reg;
        base_next      = base_reg;
        out_valid_next = out_valid_reg;
        result_next    = result_reg;
        mm_start       = 1'b0;
        mm_x           = base_reg;
        mm_y           = base_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    // The message mod m is 1 * message through the multiplier.
                    mm_start   = 1'b1;
                    mm_x       = WORD_WIDTH'(1);
                    mm_y       = message;
                    exp_next   = operation ? priv_exp_reg : pub_exp_reg;
                    acc_next   = WORD_WIDTH'(1);
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                if (mm_status.done)
                begin
                    base_next  = mm_product;
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (exp_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
                else if (exp_reg[0])
                begin
                    mm_start   = 1'b1;
                    mm_x       = acc_reg;
                    state_next = ST_MULT;
                end
                else
                begin
                    mm_start   = 1'b1;
                    state_next = ST_SQUARE;
                end
            end
            ST_MULT:
            begin
                if (mm_status.done)
                begin
                    acc_next = mm_product;
                    // No square is needed after the last set bit.
                    if (exp_reg[WORD_WIDTH-1:1] == '0)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        mm_start   = 1'b1;
                        state_next = ST_SQUARE;
                    end
                end
            end
            ST_SQUARE:
            begin
                if (mm_status.done)
                begin
                    base_next  = mm_product;
                    exp_next   = {1'b0, exp_reg[WORD_WIDTH-1:1]};
                    state_next = ST_STEP;
                end
            end
            ST_FINISH:
            begin
                // Wait until the output register is free.
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    result_next    = acc_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working registers and the output beat.
    always_ff @(posedge clk)
    begin
        exp_reg    <= exp_next;
        acc_reg    <= acc_next;
        base_reg   <= base_next;
        result_reg <= result_next;
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

@@ design/rsa_mexp_checker.sv @@
// ----------------------------------------------------------------------------
// RSA modular exponentiation checker
// Port-level assertions on the core, attached by a bind statement.
// ----------------------------------------------------------------------------
`include "rsa_modular_exponentiation_core_assert.svh"

module rsa_mexp_checker
    import rsa_mexp_pkg::*;
#(
    parameter int WORD_WIDTH = WORD_WIDTH_DEF
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [WORD_WIDTH-1:0] result
);

    // An accepted beat keeps the core busy through the message reduction.
    `RSA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")
    `RSA_ASSERT_IMPLY(a_busy_two_cycles, in_valid && in_ready, ##2 !in_ready, "reduction too short")

    // A stalled result beat stays put.
    `RSA_ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid && $stable(result), "result dropped")

endmodule

bind rsa_modular_exponentiation_core rsa_mexp_checker #(
    .WORD_WIDTH (WORD_WIDTH)
) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result)
);
